### sv/priority_queue_sorted_insert_macros.svh
// Assertion macros shared by the priority queue RTL.
`ifndef PRIORITY_QUEUE_SORTED_INSERT_MACROS_SVH
`define PRIORITY_QUEUE_SORTED_INSERT_MACROS_SVH

// Check a property on every clock edge outside reset.
`define PQSI_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) \
        else $error(msg);

// Check that a condition is followed by a property in the next cycle.
`define PQSI_ASSERT_NEXT(label, cond, prop, msg) \
    `PQSI_ASSERT(label, (cond) |=> (prop), msg)

`endif

### sv/pqsi_pkg.sv
// Types and codes shared by the priority queue modules.
package pqsi_pkg;

    localparam logic OP_PUSH = 1'b0;
    localparam logic OP_POP  = 1'b1;

    localparam logic [1:0] ST_DONE  = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_EMPTY = 2'd2;

    typedef struct packed {
        logic        opcode;
        logic [15:0] item_value;
        logic [7:0]  item_priority;
    } t_in_item;

    typedef struct packed {
        logic [15:0] popped_value;
        logic [15:0] head_value;
        logic [7:0]  head_priority;
        logic [4:0]  entry_count;
        logic [1:0]  status;
    } t_out_item;

    typedef struct packed {
        logic [15:0] value;
        logic [7:0]  prio;
    } t_entry;

endpackage

### sv/pqsi_store.sv
// Entry memory: one write port, one read port with registered read data.
module pqsi_store #(
    parameter int DEPTH = 16,
    parameter int AW    = 4
) (
    input  logic            i_clk,
    input  logic            i_we,
    input  logic [AW-1:0]   i_waddr,
    input  pqsi_pkg::t_entry i_wdata,
    input  logic [AW-1:0]   i_raddr,
    output pqsi_pkg::t_entry o_rdata
);
    import pqsi_pkg::*;

    t_entry r_mem [DEPTH];
    t_entry r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

### sv/priority_queue_sorted_insert.sv
// Top level of the sorted-store priority queue with its insertion sequencer.
//
// Input channel: i_in_valid / o_in_stall carry one request item (push or pop).
// Output channel: o_out_valid / i_out_stall carry one result item per request.
// A transfer happens on a rising edge with valid high and stall low.
// Entries sit in a memory ordered from highest priority down; equal
// priorities keep arrival order. The front entry is mirrored in registers.
// Push: one compare unit walks from the tail toward the front; each entry
// moved takes a memory read, then a compare and write, since the memory
// read port allows one access a cycle. A new entry that lands at the
// front is written without a compare. Pop: entries move forward one
// place, each by a memory read, then a write. Refused requests go
// straight to the final step.
// o_in_stall is high while a request is in work; the next request is taken
// once the previous result has been loaded into the output register.
// When i_out_stall holds a result, the next request still runs and waits in
// its final step until the output register is free.
// Reset (synchronous, active low) empties the queue; memory is not cleared.
module priority_queue_sorted_insert #(
    parameter int DEPTH = 16
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  pqsi_pkg::t_in_item  i_item,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output pqsi_pkg::t_out_item o_result
);
    import pqsi_pkg::*;
    `include "priority_queue_sorted_insert_macros.svh"

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_PUSH_RD,
        S_PUSH_CMP,
        S_POP_RD,
        S_POP_WR,
        S_FIN
    } t_state;

    t_state          r_state, n_state;
    logic [CW-1:0]   r_count, n_count;
    logic [AW-1:0]   r_idx, n_idx;
    t_entry          r_new, n_new;
    t_entry          r_head, n_head;
    logic [15:0]     r_popped, n_popped;
    logic [1:0]      r_status, n_status;
    logic            r_out_valid, n_out_valid;
    t_out_item       r_result, n_result;

    logic            mem_we;
    logic [AW-1:0]   mem_waddr;
    t_entry          mem_wdata;
    logic [AW-1:0]   mem_raddr;
    t_entry          mem_rdata;

    logic            in_accept;
    logic            slot_free;
    logic            count_full;
    logic            more_to_move;
    logic [CW+4:0]   count_ext;

    pqsi_store #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    assign in_accept    = i_in_valid && !o_in_stall;
    assign slot_free    = !r_out_valid || !i_out_stall;
    assign count_full   = (r_count == CW'(DEPTH));
    assign more_to_move = ((CW+1)'(r_idx) + (CW+1)'(1)) < (CW+1)'(r_count);
    assign count_ext    = (CW+5)'(r_count);

    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_idx       = r_idx;
        n_new       = r_new;
        n_head      = r_head;
        n_popped    = r_popped;
        n_status    = r_status;
        n_out_valid = r_out_valid;
        n_result    = r_result;
        mem_we      = 1'b0;
        mem_waddr   = r_idx;
        mem_wdata   = r_new;
        mem_raddr   = r_idx;

        if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (in_accept) begin
                    n_new.value = i_item.item_value;
                    n_new.prio  = i_item.item_priority;
                    n_popped    = '0;
                    n_status    = ST_DONE;
                    if (i_item.opcode == OP_PUSH) begin
                        if (count_full) begin
                            n_status = ST_FULL;
                            n_state  = S_FIN;
                        end else begin
                            n_idx   = r_count[AW-1:0];
                            n_state = S_PUSH_RD;
                        end
                    end else begin
                        if (r_count == '0) begin
                            n_status = ST_EMPTY;
                            n_state  = S_FIN;
                        end else begin
                            n_popped = r_head.value;
                            n_idx    = '0;
                            n_state  = S_POP_RD;
                        end
                    end
                end
            end
            S_PUSH_RD: begin
                if (r_idx == '0) begin
                    // insert at the front
                    mem_we    = 1'b1;
                    mem_wdata = r_new;
                    n_head    = r_new;
                    n_count   = r_count + CW'(1);
                    n_state   = S_FIN;
                end else begin
                    mem_raddr = r_idx - AW'(1);
                    n_state   = S_PUSH_CMP;
                end
            end
            S_PUSH_CMP: begin
                mem_we = 1'b1;
                if (mem_rdata.prio < r_new.prio) begin
                    // move the lower-priority entry back one place
                    mem_wdata = mem_rdata;
                    n_idx     = r_idx - AW'(1);
                    n_state   = S_PUSH_RD;
                end else begin
                    mem_wdata = r_new;
                    n_count   = r_count + CW'(1);
                    n_state   = S_FIN;
                end
            end
            S_POP_RD: begin
                if (more_to_move) begin
                    mem_raddr = r_idx + AW'(1);
                    n_state   = S_POP_WR;
                end else begin
                    n_count = r_count - CW'(1);
                    n_state = S_FIN;
                end
            end
            S_POP_WR: begin
                mem_we    = 1'b1;
                mem_wdata = mem_rdata;
                if (r_idx == '0) begin
                    n_head = mem_rdata;
                end
                n_idx   = r_idx + AW'(1);
                n_state = S_POP_RD;
            end
            S_FIN: begin
                // hold until the output register can take the item
                if (slot_free) begin
                    n_out_valid            = 1'b1;
                    n_result.popped_value  = r_popped;
                    n_result.head_value    = (r_count == '0) ? 16'd0 : r_head.value;
                    n_result.head_priority = (r_count == '0) ? 8'd0 : r_head.prio;
                    n_result.entry_count   = count_ext[4:0];
                    n_result.status        = r_status;
                    n_state                = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
        r_idx    <= n_idx;
        r_new    <= n_new;
        r_head   <= n_head;
        r_popped <= n_popped;
        r_status <= n_status;
        r_result <= n_result;
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_result    = r_result;

    `PQSI_ASSERT(a_count_bound, r_count <= CW'(DEPTH), "entry count beyond depth")
    `PQSI_ASSERT_NEXT(a_accept_busy, in_accept, o_in_stall, "accepted item left block idle")
    `PQSI_ASSERT(a_full_status, (r_state == S_FIN && r_status == ST_FULL) |-> count_full,
        "push refused while store not full")
    `PQSI_ASSERT(a_cmp_idx, (r_state == S_PUSH_CMP) |-> (r_idx != '0),
        "compare step reached at front slot")

endmodule

### verif/pqsi_result_checker.sv
// Result checker for the priority queue: tracks the sorted store and compares every result.
`timescale 1ns / 100ps

module pqsi_result_checker #(
    parameter int DEPTH = 16
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    input  logic                i_in_stall,
    input  pqsi_pkg::t_in_item  i_item,
    input  logic                i_out_valid,
    input  logic                i_out_stall,
    input  pqsi_pkg::t_out_item i_result,
    output int                  o_fail_count,
    output int                  o_pending,
    output int                  o_results,
    output int                  o_full_refusals,
    output int                  o_empty_refusals
);
    import pqsi_pkg::*;

    t_entry    sorted_store[$];
    t_out_item expected_results[$];

    int fail_count     = 0;
    int accepted_reqs  = 0;
    int checked_results = 0;
    int full_refusals  = 0;
    int empty_refusals = 0;

    assign o_fail_count     = fail_count;
    assign o_pending        = accepted_reqs - checked_results;
    assign o_results        = checked_results;
    assign o_full_refusals  = full_refusals;
    assign o_empty_refusals = empty_refusals;

    // Apply one request to the store and return the result it must produce.
    function automatic t_out_item predict_request(input t_in_item req);
        t_out_item res;
        t_entry    ent;
        int        pos;
        res = '0;
        if (req.opcode == OP_PUSH) begin
            if (sorted_store.size() >= DEPTH) begin
                res.status = ST_FULL;
            end else begin
                // insert behind every entry of equal or higher priority
                pos = 0;
                while (pos < sorted_store.size() && sorted_store[pos].prio >= req.item_priority)
                    pos++;
                ent.value = req.item_value;
                ent.prio  = req.item_priority;
                sorted_store.insert(pos, ent);
                res.status = ST_DONE;
            end
        end else begin
            if (sorted_store.size() == 0) begin
                res.status = ST_EMPTY;
            end else begin
                ent = sorted_store.pop_front();
                res.popped_value = ent.value;
                res.status = ST_DONE;
            end
        end
        if (sorted_store.size() > 0) begin
            res.head_value    = sorted_store[0].value;
            res.head_priority = sorted_store[0].prio;
        end
        res.entry_count = 5'(sorted_store.size());
        return res;
    endfunction

    task automatic check_field(input string name, input logic [15:0] exp_val,
                               input logic [15:0] act_val);
        if (exp_val !== act_val) begin
            $error("%s: expected 0x%0h, got 0x%0h", name, exp_val, act_val);
            fail_count++;
        end
    endtask

    always @(posedge i_clk) begin
        t_out_item exp_res;
        if (!i_rst_n) begin
            sorted_store.delete();
            expected_results.delete();
        end else begin
            if (i_out_valid && !i_out_stall) begin
                checked_results <= checked_results + 1;
                if (expected_results.size() == 0) begin
                    $error("unexpected result item: 0x%0h", i_result);
                    fail_count++;
                end else begin
                    exp_res = expected_results.pop_front();
                    check_field("popped_value", exp_res.popped_value, i_result.popped_value);
                    check_field("head_value", exp_res.head_value, i_result.head_value);
                    check_field("head_priority", 16'(exp_res.head_priority),
                                16'(i_result.head_priority));
                    check_field("entry_count", 16'(exp_res.entry_count),
                                16'(i_result.entry_count));
                    check_field("status", 16'(exp_res.status), 16'(i_result.status));
                    if (exp_res.status == ST_FULL)  full_refusals++;
                    if (exp_res.status == ST_EMPTY) empty_refusals++;
                end
            end
            if (i_in_valid && !i_in_stall) begin
                accepted_reqs <= accepted_reqs + 1;
                expected_results.push_back(predict_request(i_item));
            end
        end
    end

endmodule

### verif/tb_top.sv
// Testbench top for the priority queue: clock, reset, request stimulus, result stalls, verdict.
`timescale 1ns / 100ps

module tb_top;
    import pqsi_pkg::*;

    localparam int DEPTH       = 16;
    localparam int MAX_WAIT    = 18;
    localparam int N_RANDOM    = 1925;
    localparam int IDLE_LIMIT  = 1000;
    localparam int SETTLE_CYCLES = 2 * DEPTH + 8;

    logic      i_clk      = 1'b0;
    logic      i_rst_n    = 1'b0;
    logic      in_valid   = 1'b0;
    t_in_item  in_item    = '0;
    logic      out_stall  = 1'b0;
    logic      o_in_stall;
    logic      o_out_valid;
    t_out_item o_result;

    int fail_count;
    int pending;
    int results_seen;
    int full_refusals;
    int empty_refusals;

    int idle_cycles = 0;
    int stall_left  = 0;
    int stall_draw;
    bit rx_burst    = 1'b0;

    priority_queue_sorted_insert #(.DEPTH(DEPTH)) i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (o_in_stall),
        .i_item      (in_item),
        .o_out_valid (o_out_valid),
        .i_out_stall (out_stall),
        .o_result    (o_result)
    );

    pqsi_result_checker #(.DEPTH(DEPTH)) i_checker (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (in_valid),
        .i_in_stall       (o_in_stall),
        .i_item           (in_item),
        .i_out_valid      (o_out_valid),
        .i_out_stall      (out_stall),
        .i_result         (o_result),
        .o_fail_count     (fail_count),
        .o_pending        (pending),
        .o_results        (results_seen),
        .o_full_refusals  (full_refusals),
        .o_empty_refusals (empty_refusals)
    );

    initial begin
        forever #2 i_clk = ~i_clk;
    end

    // Result side: per item, hold stall for a drawn number of valid cycles.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_stall  <= 1'b0;
            stall_left <= 0;
        end else if (o_out_valid && !out_stall) begin
            if ($urandom_range(0, 49) == 0) rx_burst = !rx_burst;
            stall_draw = rx_burst ? 0 : $urandom_range(0, MAX_WAIT);
            stall_left <= stall_draw;
            out_stall  <= (stall_draw != 0);
        end else if (o_out_valid && stall_left > 0) begin
            if (stall_left == 1) out_stall <= 1'b0;
            stall_left <= stall_left - 1;
        end
    end

    // End the run when no item moves on either channel for too long.
    always @(posedge i_clk) begin
        if ((in_valid && !o_in_stall) || (o_out_valid && !out_stall)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("watchdog: no item moved for %0d cycles", IDLE_LIMIT);
                $display("TEST FAILED");
                $finish;
            end
        end
    end

    function automatic t_in_item make_req(input logic op, input logic [15:0] val,
                                          input logic [7:0] prio);
        t_in_item req;
        req.opcode        = op;
        req.item_value    = val;
        req.item_priority = prio;
        return req;
    endfunction

    // Drop valid for the gap, present the item, and hold it until accepted.
    task automatic put_item(input t_in_item req, input int gap);
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_valid <= 1'b1;
        in_item  <= req;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
    endtask

    // Hold off requests until every outstanding result has come back.
    task automatic wait_drained();
        in_valid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
    endtask

    initial begin
        bit          tx_burst;
        int          mode;
        int          push_pct;
        int          sel;
        logic        op;
        logic [15:0] val;
        logic [7:0]  prio;

        tx_burst = 1'b0;
        mode     = 0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: empty pop, extremes, ties, fill to full, refused push.
        put_item(make_req(OP_POP, 16'hFFFF, 8'hFF), $urandom_range(0, MAX_WAIT));
        put_item(make_req(OP_PUSH, 16'hFFFF, 8'h00), $urandom_range(0, MAX_WAIT));
        put_item(make_req(OP_PUSH, 16'h0000, 8'hFF), $urandom_range(0, MAX_WAIT));
        put_item(make_req(OP_PUSH, 16'h1234, 8'hFF), $urandom_range(0, MAX_WAIT));
        put_item(make_req(OP_PUSH, 16'h8001, 8'h80), $urandom_range(0, MAX_WAIT));
        put_item(make_req(OP_POP, 16'h0000, 8'h00), $urandom_range(0, MAX_WAIT));
        put_item(make_req(OP_POP, 16'hA5A5, 8'h5A), $urandom_range(0, MAX_WAIT));
        for (int k = 0; k < DEPTH - 2; k++) begin
            case (k % 4)
                0: prio = 8'hFF;
                1: prio = 8'h00;
                2: prio = 8'h80;
                default: prio = 8'h01;
            endcase
            put_item(make_req(OP_PUSH, 16'h5A00 + 16'(k), prio), (k < 6) ? 0 : 3);
        end
        put_item(make_req(OP_PUSH, 16'h7777, 8'hFF), 0);
        put_item(make_req(OP_POP, 16'h5555, 8'hAA), 0);
        wait_drained();

        // Random: phases biased toward filling, draining, or mixed traffic.
        for (int n = 0; n < N_RANDOM; n++) begin
            if (n % 32 == 0) mode = $urandom_range(0, 2);
            push_pct = (mode == 0) ? 85 : (mode == 1) ? 15 : 50;
            op = ($urandom_range(0, 99) < push_pct) ? OP_PUSH : OP_POP;

            sel = $urandom_range(0, 7);
            if (sel == 0)      val = 16'h0000;
            else if (sel == 1) val = 16'hFFFF;
            else               val = 16'($urandom);

            sel = $urandom_range(0, 7);
            if (sel < 2)      prio = sel[0] ? 8'hFF : 8'h00;
            else if (sel < 5) prio = 8'(100 + $urandom_range(0, 3));  // tie-rich
            else              prio = 8'($urandom);

            if ($urandom_range(0, 49) == 0) tx_burst = !tx_burst;
            if ($urandom_range(0, 149) == 0) wait_drained();
            put_item(make_req(op, val, prio), tx_burst ? 0 : $urandom_range(0, MAX_WAIT));
        end
        in_valid <= 1'b0;

        while (pending != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        $display("Checked %0d results over directed and random push/pop traffic.",
                 results_seen);
        $display("Refused pushes at full: %0d, refused pops on empty: %0d.",
                 full_refusals, empty_refusals);
        if (fail_count == 0 && pending == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

### priority_queue_sorted_insert.f
+incdir+sv
sv/pqsi_pkg.sv
sv/pqsi_store.sv
sv/priority_queue_sorted_insert.sv
verif/pqsi_result_checker.sv
verif/tb_top.sv
